### rtl/jmm_pkg.sv
// Shared types and constants for the joystick mecanum mixer.
package jmm_pkg;

    // Message tags.
    localparam logic [7:0] TAG_LEFT  = 8'd76;
    localparam logic [7:0] TAG_RIGHT = 8'd82;

    // Axis and drive scaling.
    localparam int AXIS_IN_MIN  = 10;
    localparam int AXIS_SCALE   = 254;
    localparam int AXIS_OUT_MAX = 127;
    localparam int DRIVE_MAX    = 1000;

    // Reciprocal for an exact floor divide by 5 of a 16-bit value.
    localparam logic [15:0] DIV5_RECIP  = 16'd52429;
    // Reciprocal for an exact floor divide by 127 of a 25-bit value.
    localparam logic [25:0] DIV127_RECIP = 26'd33818641;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE     = 2'd1;
    localparam int CFG_DATA_W = 10;

    // Register reset values.
    localparam logic [9:0] DEADBAND_RESET = 10'd200;
    localparam logic [6:0] IDLE_RESET     = 7'd50;

    // Register stages from an accepted command to the result strobe.
    localparam int PIPE_DEPTH = 7;

    // Widths of internal values.
    localparam int AXIS_W  = 14;
    localparam int MAG_W   = 15;
    localparam int MOTOR_N = 4;

    typedef logic signed [AXIS_W-1:0] t_axis;

    typedef struct packed {
        logic [7:0] left_tag;
        logic [7:0] left_x_tens;
        logic [7:0] left_x_ones;
        logic [7:0] left_y_tens;
        logic [7:0] left_y_ones;
        logic [7:0] right_tag;
        logic [7:0] right_x_tens;
        logic [7:0] right_x_ones;
        logic [7:0] right_y_tens;
        logic [7:0] right_y_ones;
    } t_cmd_word;

    typedef struct packed {
        logic       front_left_forward;
        logic [9:0] front_left_duty;
        logic       front_right_forward;
        logic [9:0] front_right_duty;
        logic       rear_right_forward;
        logic [9:0] rear_right_duty;
        logic       rear_left_forward;
        logic [9:0] rear_left_duty;
    } t_result_word;

    // One mixed sum, offset and split into sign and magnitude.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_mix_val;

endpackage

### rtl/jmm_axis_map.sv
// Parses one stick axis from two ASCII digits and maps it to -127..127 scale.
module jmm_axis_map
    import jmm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_tag_ok,
    input  logic [7:0] i_tens,
    input  logic [7:0] i_ones,
    input  logic [6:0] i_idle,
    output t_axis      o_axis
);

    logic signed [12:0] tens_v;
    logic signed [12:0] ones_v;
    logic signed [12:0] n_axis;
    logic signed [12:0] r_axis;

    logic signed [20:0] ofs;
    logic signed [20:0] prod;
    logic        [20:0] mag;
    logic        [15:0] n_hi;
    logic               n_neg;
    logic        [15:0] r_hi;
    logic               r_neg;

    logic        [31:0] qprod;
    logic signed [13:0] qs;
    t_axis              n_m;
    t_axis              r_m;

    // Stage one: digits to an axis value, or the idle value on a tag mismatch.
    always_comb begin
        tens_v = $signed({5'b0, i_tens}) - 13'sd48;
        ones_v = $signed({5'b0, i_ones}) - 13'sd48;
        if (i_tag_ok) begin
            n_axis = tens_v * 13'sd10 + ones_v;
        end else begin
            n_axis = $signed({6'b0, i_idle});
        end
    end

    // Stage two: offset and scale, then split into sign and magnitude / 16.
    always_comb begin
        ofs   = {{8{r_axis[12]}}, r_axis};
        ofs   = ofs - 21'(AXIS_IN_MIN);
        prod  = ofs * 21'(AXIS_SCALE);
        n_neg = prod[20];
        mag   = prod[20] ? 21'(-prod) : prod;
        n_hi  = mag[19:4];
    end

    // Stage three: finish the divide by 80 with a reciprocal, restore the sign, subtract 127.
    always_comb begin
        qprod = {16'b0, r_hi} * {16'b0, DIV5_RECIP};
        qs    = $signed({1'b0, qprod[30:18]});
        n_m   = (r_neg ? -qs : qs) - 14'(AXIS_OUT_MAX);
    end

    always_ff @(posedge i_clk) begin
        r_axis <= n_axis;
        r_hi   <= n_hi;
        r_neg  <= n_neg;
        r_m    <= n_m;
    end

    assign o_axis = r_m;

endmodule

### rtl/jmm_mix.sv
// Forms the four mecanum wheel sums from the mapped stick axes.
module jmm_mix
    import jmm_pkg::*;
(
    input  logic     i_clk,
    input  t_axis    i_lx,
    input  t_axis    i_ly,
    input  t_axis    i_rx,
    input  t_axis    i_ry,
    output t_mix_val o_val [MOTOR_N]
);

    logic signed [16:0] lx;
    logic signed [16:0] ly;
    logic signed [16:0] rx;
    logic signed [16:0] ry;
    logic signed [16:0] base;
    logic signed [16:0] sum [MOTOR_N];
    logic signed [16:0] v   [MOTOR_N];
    logic        [16:0] vmag [MOTOR_N];
    t_mix_val           n_val [MOTOR_N];
    t_mix_val           r_val [MOTOR_N];

    // Sums in motor order, offset by 127 and split into sign and magnitude.
    always_comb begin
        lx     = {{3{i_lx[AXIS_W-1]}}, i_lx};
        ly     = {{3{i_ly[AXIS_W-1]}}, i_ly};
        rx     = {{3{i_rx[AXIS_W-1]}}, i_rx};
        ry     = {{3{i_ry[AXIS_W-1]}}, i_ry};
        base   = -ly - ry;
        sum[0] = base + lx + rx;
        sum[1] = base - lx - rx;
        sum[2] = base + lx - rx;
        sum[3] = base - lx + rx;
        for (int k = 0; k < MOTOR_N; k++) begin
            v[k]         = sum[k] + 17'(AXIS_OUT_MAX);
            vmag[k]      = v[k][16] ? 17'(-v[k]) : v[k];
            n_val[k].neg = v[k][16];
            n_val[k].mag = vmag[k][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

### rtl/jmm_drive_map.sv
// Maps one wheel sum to a duty value with deadband and clamp.
module jmm_drive_map
    import jmm_pkg::*;
(
    input  logic       i_clk,
    input  t_mix_val   i_val,
    input  logic [9:0] i_deadband,
    output logic       o_forward,
    output logic [9:0] o_duty
);

    logic        [24:0] n_y;
    logic        [24:0] r_y;
    logic               r_neg_a;
    logic        [50:0] zprod;
    logic        [17:0] r_z;
    logic               r_neg_b;
    logic signed [19:0] zs;
    logic signed [19:0] d;
    logic signed [19:0] db;
    logic        [19:0] dmag;
    logic               n_forward;
    logic        [9:0]  n_duty;
    logic               r_forward;
    logic        [9:0]  r_duty;

    // Stage one: scale the magnitude by 1000.
    assign n_y = {10'b0, i_val.mag} * 25'(DRIVE_MAX);

    // Stage two: divide by 127 with a reciprocal multiply.
    assign zprod = {26'b0, r_y} * {25'b0, DIV127_RECIP};

    // Stage three: restore the sign, remove the offset, deadband and clamp.
    always_comb begin
        zs = {2'b0, r_z};
        db = {10'b0, i_deadband};
        d  = (r_neg_b ? -zs : zs) - 20'(DRIVE_MAX);
        if (d < db && d > -db) begin
            d = '0;
        end
        if (d > 20'(DRIVE_MAX)) begin
            d = 20'(DRIVE_MAX);
        end
        if (d < -20'(DRIVE_MAX)) begin
            d = -20'(DRIVE_MAX);
        end
        n_forward = !d[19];
        dmag      = d[19] ? 20'(-d) : d;
        n_duty    = dmag[9:0];
    end

    always_ff @(posedge i_clk) begin
        r_y       <= n_y;
        r_neg_a   <= i_val.neg;
        r_z       <= zprod[49:32];
        r_neg_b   <= r_neg_a;
        r_forward <= n_forward;
        r_duty    <= n_duty;
    end

    assign o_forward = r_forward;
    assign o_duty    = r_duty;

endmodule

### rtl/joystick_mecanum_mixer_unit.sv
// Top level of the joystick mecanum mixer: parse, mix and map to wheel duties.
//
// Command channel: a word (two joystick messages) is taken at every rising
// edge where start is high and busy is low. busy is always low, so a new
// word may be given in every cycle.
// Result channel: each word yields one result word, shown on o_result for
// exactly one cycle while o_valid is high. The receiver cannot hold it off.
// Throughput is one word per cycle. Each word passes through seven register
// stages: parse, axis scale, divide by 80, wheel sums, scale by 1000, divide
// by 127, deadband and clamp.
// Configuration channel: i_cfg_valid/o_cfg_ready with an index and data;
// index 0 is the deadband limit, index 1 the idle axis value, others are
// ignored. o_cfg_ready is always high. Write only while no word is in flight.
// Reset (synchronous, active low) drops all words in flight and restores
// the deadband limit to 200 and the idle axis value to 50.
module joystick_mecanum_mixer_unit
    import jmm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd_word             i_cmd,
    output logic                  o_valid,
    output t_result_word          o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [9:0]            r_deadband;
    logic [6:0]            r_idle;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic                  left_ok;
    logic                  right_ok;
    t_axis                 lx;
    t_axis                 ly;
    t_axis                 rx;
    t_axis                 ry;
    t_mix_val              mix_val [MOTOR_N];
    logic                  fwd  [MOTOR_N];
    logic [9:0]            duty [MOTOR_N];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DEADBAND_RESET;
            r_idle     <= IDLE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEADBAND: r_deadband <= i_cfg_data[9:0];
                REG_IDLE:     r_idle     <= i_cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    // Valid bits follow the words through the stages.
    assign n_vld = {r_vld[PIPE_DEPTH-2:0], start && !busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign left_ok  = (i_cmd.left_tag == TAG_LEFT);
    assign right_ok = (i_cmd.right_tag == TAG_RIGHT);

    // Four axis mappers.
    jmm_axis_map u_axis_lx (
        .i_clk   (i_clk),
        .i_tag_ok(left_ok),
        .i_tens  (i_cmd.left_x_tens),
        .i_ones  (i_cmd.left_x_ones),
        .i_idle  (r_idle),
        .o_axis  (lx)
    );

    jmm_axis_map u_axis_ly (
        .i_clk   (i_clk),
        .i_tag_ok(left_ok),
        .i_tens  (i_cmd.left_y_tens),
        .i_ones  (i_cmd.left_y_ones),
        .i_idle  (r_idle),
        .o_axis  (ly)
    );

    jmm_axis_map u_axis_rx (
        .i_clk   (i_clk),
        .i_tag_ok(right_ok),
        .i_tens  (i_cmd.right_x_tens),
        .i_ones  (i_cmd.right_x_ones),
        .i_idle  (r_idle),
        .o_axis  (rx)
    );

    jmm_axis_map u_axis_ry (
        .i_clk   (i_clk),
        .i_tag_ok(right_ok),
        .i_tens  (i_cmd.right_y_tens),
        .i_ones  (i_cmd.right_y_ones),
        .i_idle  (r_idle),
        .o_axis  (ry)
    );

    // Wheel sums.
    jmm_mix u_mix (
        .i_clk(i_clk),
        .i_lx (lx),
        .i_ly (ly),
        .i_rx (rx),
        .i_ry (ry),
        .o_val(mix_val)
    );

    // One drive mapper per wheel.
    for (genvar g = 0; g < MOTOR_N; g++) begin : g_drive
        jmm_drive_map u_drive (
            .i_clk     (i_clk),
            .i_val     (mix_val[g]),
            .i_deadband(r_deadband),
            .o_forward (fwd[g]),
            .o_duty    (duty[g])
        );
    end

    // Result word in motor order.
    always_comb begin
        o_result.front_left_forward  = fwd[0];
        o_result.front_left_duty     = duty[0];
        o_result.front_right_forward = fwd[1];
        o_result.front_right_duty    = duty[1];
        o_result.rear_right_forward  = fwd[2];
        o_result.rear_right_duty     = duty[2];
        o_result.rear_left_forward   = fwd[3];
        o_result.rear_left_duty      = duty[3];
    end

    assign o_valid = r_vld[PIPE_DEPTH-1];

endmodule

### rtl/jmm_checker.sv
// Port-level checks for the joystick mecanum mixer and their binding.
module jmm_checker
    import jmm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input t_result_word          o_result
);

    // Every accepted word produces a result after the full pipeline.
    a_word_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##7 o_valid)
        else $error("accepted word produced no result");

    // No result appears without a word accepted one full pipeline depth earlier.
    a_result_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 7))
        else $error("result without an accepted word");

    // Duties stay within the clamp.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.front_left_duty <= 10'd1000
                 && o_result.front_right_duty <= 10'd1000
                 && o_result.rear_right_duty <= 10'd1000
                 && o_result.rear_left_duty <= 10'd1000)
        else $error("duty above limit");

    // A zero drive value always reports the forward direction.
    a_zero_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.front_left_duty != 10'd0 || o_result.front_left_forward)
                 && (o_result.front_right_duty != 10'd0 || o_result.front_right_forward)
                 && (o_result.rear_right_duty != 10'd0 || o_result.rear_right_forward)
                 && (o_result.rear_left_duty != 10'd0 || o_result.rear_left_forward))
        else $error("zero duty with reverse direction");

endmodule

bind joystick_mecanum_mixer_unit jmm_checker u_jmm_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the joystick mecanum mixer unit: directed and random words.
module tb_top;
    import jmm_pkg::*;

    localparam int DIGIT_ZERO  = 48;
    localparam int AXIS_SPAN   = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_cmd_word             i_cmd       = '0;
    logic                  o_valid;
    t_result_word          o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_DEADBAND;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Local copy of the two registers, kept in step with accepted writes.
    logic [9:0] deadband_reg = DEADBAND_RESET;
    logic [6:0] idle_reg     = IDLE_RESET;

    t_result_word pending_wheel_cmds[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           gaps_on     = 1'b1;

    joystick_mecanum_mixer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Two raw bytes become one axis value; non-digit bytes are taken as they are.
    function automatic int digits_to_axis(logic [7:0] tens, logic [7:0] ones);
        return (int'(tens) - DIGIT_ZERO) * 10 + (int'(ones) - DIGIT_ZERO);
    endfunction

    // Axis range 10..90 onto -127..127, truncating toward zero.
    function automatic int scale_axis(int a);
        return (a - AXIS_IN_MIN) * AXIS_SCALE / AXIS_SPAN - AXIS_OUT_MAX;
    endfunction

    // Wheel sum onto -1000..1000, then deadband and clamp.
    function automatic int wheel_drive(int s, int db);
        int d;
        d = (s + AXIS_OUT_MAX) * (2 * DRIVE_MAX) / (2 * AXIS_OUT_MAX) - DRIVE_MAX;
        if (d < db && d > -db)
            d = 0;
        if (d > DRIVE_MAX)
            d = DRIVE_MAX;
        if (d < -DRIVE_MAX)
            d = -DRIVE_MAX;
        return d;
    endfunction

    // Expected motor directions and duties for one command word.
    function automatic t_result_word predict_wheels(t_cmd_word c, int db, int idle);
        int lx, ly, rx, ry;
        int mlx, mly, mrx, mry;
        int d [4];
        t_result_word r;
        lx = idle;
        ly = idle;
        rx = idle;
        ry = idle;
        if (c.left_tag == TAG_LEFT) begin
            lx = digits_to_axis(c.left_x_tens, c.left_x_ones);
            ly = digits_to_axis(c.left_y_tens, c.left_y_ones);
        end
        if (c.right_tag == TAG_RIGHT) begin
            rx = digits_to_axis(c.right_x_tens, c.right_x_ones);
            ry = digits_to_axis(c.right_y_tens, c.right_y_ones);
        end
        mlx = scale_axis(lx);
        mly = scale_axis(ly);
        mrx = scale_axis(rx);
        mry = scale_axis(ry);
        d[0] = wheel_drive(-mly + mlx - mry + mrx, db);
        d[1] = wheel_drive(-mly - mlx - mry - mrx, db);
        d[2] = wheel_drive(-mly + mlx - mry - mrx, db);
        d[3] = wheel_drive(-mly - mlx - mry + mrx, db);
        r.front_left_forward  = d[0] >= 0;
        r.front_left_duty     = 10'(d[0] < 0 ? -d[0] : d[0]);
        r.front_right_forward = d[1] >= 0;
        r.front_right_duty    = 10'(d[1] < 0 ? -d[1] : d[1]);
        r.rear_right_forward  = d[2] >= 0;
        r.rear_right_duty     = 10'(d[2] < 0 ? -d[2] : d[2]);
        r.rear_left_forward   = d[3] >= 0;
        r.rear_left_duty      = 10'(d[3] < 0 ? -d[3] : d[3]);
        return r;
    endfunction

    function automatic logic [15:0] ascii_pair(int v);
        return {8'(DIGIT_ZERO + v / 10), 8'(DIGIT_ZERO + v % 10)};
    endfunction

    // A well-formed pair of messages with the given stick positions.
    function automatic t_cmd_word stick_cmd(int lx, int ly, int rx, int ry);
        t_cmd_word c;
        c.left_tag  = TAG_LEFT;
        c.right_tag = TAG_RIGHT;
        {c.left_x_tens, c.left_x_ones}   = ascii_pair(lx);
        {c.left_y_tens, c.left_y_ones}   = ascii_pair(ly);
        {c.right_x_tens, c.right_x_ones} = ascii_pair(rx);
        {c.right_y_tens, c.right_y_ones} = ascii_pair(ry);
        return c;
    endfunction

    function automatic int random_axis();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(10, 90);
    endfunction

    // Mostly well-formed messages; the rest have broken tags or raw noise bytes.
    function automatic t_cmd_word random_cmd();
        t_cmd_word   c;
        int          kind;
        logic [95:0] raw;
        kind = $urandom_range(0, 15);
        c = stick_cmd(random_axis(), random_axis(), random_axis(), random_axis());
        if (kind == 12 || kind == 13) begin
            if ($urandom_range(0, 1))
                c.left_tag = 8'($urandom);
            else
                c.right_tag = 8'($urandom);
        end else if (kind >= 14) begin
            raw = {$urandom, $urandom, $urandom};
            c = raw[79:0];
            if ($urandom_range(0, 1)) begin
                c.left_tag  = TAG_LEFT;
                c.right_tag = TAG_RIGHT;
            end
        end
        return c;
    endfunction

    function automatic int random_deadband();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 400);
    endfunction

    task automatic check_field(string name, logic [9:0] want, logic [9:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Scoreboard: checks each result word and predicts each accepted command word.
    always @(posedge i_clk) begin
        t_result_word want;
        if (!i_rst_n) begin
            deadband_reg = DEADBAND_RESET;
            idle_reg     = IDLE_RESET;
            pending_wheel_cmds.delete();
        end else begin
            if (o_valid) begin
                if (pending_wheel_cmds.size() == 0) begin
                    $error("result word with no command word pending");
                    error_count++;
                end else begin
                    want = pending_wheel_cmds.pop_front();
                    check_field("front_left_forward", want.front_left_forward,
                                o_result.front_left_forward);
                    check_field("front_left_duty", want.front_left_duty,
                                o_result.front_left_duty);
                    check_field("front_right_forward", want.front_right_forward,
                                o_result.front_right_forward);
                    check_field("front_right_duty", want.front_right_duty,
                                o_result.front_right_duty);
                    check_field("rear_right_forward", want.rear_right_forward,
                                o_result.rear_right_forward);
                    check_field("rear_right_duty", want.rear_right_duty,
                                o_result.rear_right_duty);
                    check_field("rear_left_forward", want.rear_left_forward,
                                o_result.rear_left_forward);
                    check_field("rear_left_duty", want.rear_left_duty,
                                o_result.rear_left_duty);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEADBAND: deadband_reg = i_cfg_data;
                    REG_IDLE:     idle_reg = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                pending_wheel_cmds.push_back(predict_wheels(i_cmd, deadband_reg, idle_reg));
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("joystick_mecanum_mixer_unit regression: fail");
            $finish;
        end
    end

    // Sends one command word; start stays high so the next word can follow at once.
    task automatic send_cmd(t_cmd_word c);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    // Stops sending and waits until every pending result word has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_wheel_cmds.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes both registers, with junk in the unused idle bits and a write to a spare index.
    task automatic set_regs(int db, int idle);
        write_reg(REG_DEADBAND, 10'(db));
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 10'($urandom));
        write_reg(REG_IDLE, {3'($urandom), 7'(idle)});
        i_cfg_valid <= 1'b0;
    endtask

    // Stick extremes, tag handling, raw bytes and the deadband edge at reset settings.
    task automatic test_directed_points();
        t_cmd_word c;
        send_cmd(stick_cmd(50, 50, 50, 50));
        send_cmd(stick_cmd(10, 10, 50, 50));
        send_cmd(stick_cmd(10, 90, 50, 50));
        send_cmd(stick_cmd(90, 10, 50, 50));
        send_cmd(stick_cmd(90, 90, 50, 50));
        send_cmd(stick_cmd(50, 50, 10, 10));
        send_cmd(stick_cmd(50, 50, 10, 90));
        send_cmd(stick_cmd(50, 50, 90, 10));
        send_cmd(stick_cmd(50, 50, 90, 90));
        send_cmd(stick_cmd(10, 10, 10, 10));
        send_cmd(stick_cmd(90, 90, 90, 90));
        send_cmd(stick_cmd(90, 10, 90, 10));
        // Axis values outside 10..90, so negative truncation and clamping show up.
        send_cmd(stick_cmd(0, 0, 99, 99));
        send_cmd(stick_cmd(99, 0, 0, 99));
        // Tags swapped, so both sticks fall back to idle; then a zero and an all-ones tag, so one stick at a time does.
        c = stick_cmd(90, 90, 10, 10);
        c.left_tag  = TAG_RIGHT;
        c.right_tag = TAG_LEFT;
        send_cmd(c);
        c.left_tag  = 8'h00;
        c.right_tag = TAG_RIGHT;
        send_cmd(c);
        c.left_tag  = TAG_LEFT;
        c.right_tag = 8'hFF;
        send_cmd(c);
        // Raw bytes that are not digits at all.
        c = '0;
        c.left_tag  = TAG_LEFT;
        c.right_tag = TAG_RIGHT;
        send_cmd(c);
        c = '1;
        c.left_tag  = TAG_LEFT;
        c.right_tag = TAG_RIGHT;
        send_cmd(c);
        // Positions just inside and just outside the default deadband.
        send_cmd(stick_cmd(58, 50, 50, 50));
        send_cmd(stick_cmd(59, 50, 50, 50));
        send_cmd(stick_cmd(42, 50, 50, 50));
        send_cmd(stick_cmd(43, 50, 50, 50));
        drain();
    endtask

    // Register values at and beyond their stated ranges.
    task automatic test_register_extremes();
        int db_set [5]   = '{0, 1000, 1023, 0, 1};
        int idle_set [5] = '{0, 99, 127, 127, 10};
        t_cmd_word c;
        for (int k = 0; k < 5; k++) begin
            set_regs(db_set[k], idle_set[k]);
            c = stick_cmd(90, 10, 90, 10);
            c.left_tag  = 8'h00;
            c.right_tag = TAG_LEFT;
            send_cmd(c);
            c.left_tag = TAG_LEFT;
            send_cmd(c);
            c.left_tag  = TAG_RIGHT;
            c.right_tag = TAG_RIGHT;
            send_cmd(c);
            send_cmd(stick_cmd(50, 50, 50, 50));
            send_cmd(stick_cmd(10, 90, 90, 10));
            send_cmd(random_cmd());
            drain();
        end
    endtask

    // Deadband set to a duty the next word produces, or one above it, so the strict bound is exercised.
    task automatic test_deadband_edges();
        t_cmd_word    c;
        t_result_word r;
        int           db;
        for (int k = 0; k < 8; k++) begin
            c = random_cmd();
            r = predict_wheels(c, 0, idle_reg);
            case ($urandom_range(0, 3))
                0: db = r.front_left_duty;
                1: db = r.front_right_duty;
                2: db = r.rear_right_duty;
                default: db = r.rear_left_duty;
            endcase
            if ($urandom_range(0, 2) == 0)
                db = db + 1;
            set_regs(db, idle_reg);
            send_cmd(c);
            send_cmd(random_cmd());
            send_cmd(c);
            send_cmd(random_cmd());
            drain();
        end
    endtask

    // Random words under random register settings, with sender gaps.
    task automatic test_random_mix();
        for (int p = 0; p < 6; p++) begin
            set_regs(random_deadband(),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(10, 90));
            repeat (235) send_cmd(random_cmd());
            drain();
        end
    endtask

    // Final stretch: one word every cycle, no gaps.
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        set_regs(random_deadband(), $urandom_range(0, 127));
        repeat (250) send_cmd(random_cmd());
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_points();
        test_register_extremes();
        test_deadband_edges();
        test_random_mix();
        test_back_to_back();
        if (error_count == 0) begin
            $display("joystick_mecanum_mixer_unit regression: pass");
        end else begin
            $display("joystick_mecanum_mixer_unit regression: fail");
        end
        $finish;
    end

endmodule
